/* rtl/feature_pair_match_threshold_unit_macros.svh */
// Assertion macros used by the checker file of the feature pair match unit.
`ifndef FEATURE_PAIR_MATCH_THRESHOLD_UNIT_MACROS_SVH
`define FEATURE_PAIR_MATCH_THRESHOLD_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FPMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define FPMT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/fpmt_pkg.sv */
// Shared widths, types and codes of the feature pair match unit.
`default_nettype none
package fpmt_pkg;

  localparam int ELEM_W   = 16;                        // Q4.12 element
  localparam int DIFF_W   = 43;                        // squared difference sum
  localparam int SUM_W    = 41;                        // product and square sums
  localparam int DIST_W   = 48;                        // distance limit
  localparam int COS_W    = 16;                        // cosine limit, Q1.15
  localparam int CFG_W    = DIST_W;                    // widest register
  localparam int CFG_IDX_W = 2;
  localparam int TDATA_IN_W  = 2 * ELEM_W;
  localparam int TDATA_OUT_W = 8;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_METRIC_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COSINE_LIMIT   = 2'd2;

  localparam logic MODE_EUCLID = 1'b0;
  localparam logic MODE_COSINE = 1'b1;

  // Sums of one finished vector pair.
  typedef struct packed {
    logic [DIFF_W-1:0] diff_sq;
    logic [SUM_W-1:0]  prod_abs;
    logic [SUM_W-1:0]  left_sq;
    logic [SUM_W-1:0]  right_sq;
  } totals_t;

  // Configuration as seen by the compare sequencer.
  typedef struct packed {
    logic              metric_mode;
    logic [DIST_W-1:0] distance_limit;
    logic [COS_W-1:0]  cosine_limit;
  } cfg_t;

endpackage
`default_nettype wire

/* rtl/fpmt_front.sv */
// Front end: element products and saturating accumulation per vector pair.
`default_nettype none
module fpmt_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [fpmt_pkg::ELEM_W-1:0]       left_value,
  input  wire logic [fpmt_pkg::ELEM_W-1:0]       right_value,
  input  wire logic                              final_element,
  output logic                                   push_valid,
  input  wire logic                              push_ready,
  output fpmt_pkg::totals_t                      push_data
);

  localparam int EW    = fpmt_pkg::ELEM_W;
  localparam int DSQ_W = 2 * EW;        // |a-b|^2
  localparam int PSQ_W = 2 * EW - 1;    // |a|*|b|, a^2, b^2

  function automatic logic [fpmt_pkg::DIFF_W-1:0] sat_diff(
    input logic [fpmt_pkg::DIFF_W-1:0] acc,
    input logic [DSQ_W-1:0]            add
  );
    logic [fpmt_pkg::DIFF_W:0] s;
    s = {1'b0, acc} + {{(fpmt_pkg::DIFF_W + 1 - DSQ_W){1'b0}}, add};
    sat_diff = s[fpmt_pkg::DIFF_W] ? {fpmt_pkg::DIFF_W{1'b1}} : s[fpmt_pkg::DIFF_W-1:0];
  endfunction

  function automatic logic [fpmt_pkg::SUM_W-1:0] sat_sum(
    input logic [fpmt_pkg::SUM_W-1:0] acc,
    input logic [PSQ_W-1:0]           add
  );
    logic [fpmt_pkg::SUM_W:0] s;
    s = {1'b0, acc} + {{(fpmt_pkg::SUM_W + 1 - PSQ_W){1'b0}}, add};
    sat_sum = s[fpmt_pkg::SUM_W] ? {fpmt_pkg::SUM_W{1'b1}} : s[fpmt_pkg::SUM_W-1:0];
  endfunction

  logic [EW:0]   diff;
  logic [EW:0]   diff_neg;
  logic [EW-1:0] ud;
  logic [EW-1:0] ua;
  logic [EW-1:0] ub;

  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_last_r;
  logic [DSQ_W-1:0] s1_dsq_r;
  logic [PSQ_W-1:0] s1_pab_r;
  logic [PSQ_W-1:0] s1_lsq_r;
  logic [PSQ_W-1:0] s1_rsq_r;

  fpmt_pkg::totals_t acc_r, acc_nxt;
  fpmt_pkg::totals_t sums;
  logic              advance;
  logic [2*EW-1:0]   pab_full;
  logic [2*EW-1:0]   lsq_full;
  logic [2*EW-1:0]   rsq_full;

  // Magnitudes of the operands and of their difference.
  always_comb begin
    diff     = {left_value[EW-1], left_value} - {right_value[EW-1], right_value};
    diff_neg = ~diff + 1'b1;
    ud       = diff[EW] ? diff_neg[EW-1:0] : diff[EW-1:0];
    ua       = left_value[EW-1]  ? (~left_value + 1'b1)  : left_value;
    ub       = right_value[EW-1] ? (~right_value + 1'b1) : right_value;
    pab_full = ua * ub;
    lsq_full = ua * ua;
    rsq_full = ub * ub;
  end

  // Stage 2 moves on unless a final element waits for queue space.
  assign advance    = s1_valid_r && (!s1_last_r || push_ready);
  assign in_ready   = !s1_valid_r || advance;
  assign push_valid = s1_valid_r && s1_last_r;

  always_comb begin
    sums.diff_sq  = sat_diff(acc_r.diff_sq, s1_dsq_r);
    sums.prod_abs = sat_sum(acc_r.prod_abs, s1_pab_r);
    sums.left_sq  = sat_sum(acc_r.left_sq, s1_lsq_r);
    sums.right_sq = sat_sum(acc_r.right_sq, s1_rsq_r);
    push_data     = sums;
    acc_nxt       = acc_r;
    if (advance) begin
      acc_nxt = s1_last_r ? '0 : sums;
    end
    s1_valid_nxt = in_valid && in_ready ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      acc_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      acc_r      <= acc_nxt;
    end
  end

  // Product register: load on every accepted element.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_last_r <= final_element;
      s1_dsq_r  <= ud * ud;
      s1_pab_r  <= pab_full[PSQ_W-1:0];
      s1_lsq_r  <= lsq_full[PSQ_W-1:0];
      s1_rsq_r  <= rsq_full[PSQ_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/fpmt_queue.sv */
// Short queue of finished vector sums between front end and compare sequencer.
`default_nettype none
module fpmt_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push_valid,
  output logic             push_ready,
  input  wire fpmt_pkg::totals_t push_data,
  output logic             pop_valid,
  input  wire logic        pop_ready,
  output fpmt_pkg::totals_t pop_data
);

  localparam int PW = fpmt_pkg::Q_PTR_W;

  fpmt_pkg::totals_t mem [fpmt_pkg::Q_DEPTH];

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count_r != (PW + 1)'(fpmt_pkg::Q_DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr_r];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(fpmt_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + (PW + 1)'(do_push) - (PW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/fpmt_back.sv */
// Compare sequencer: threshold tests with a shared shift-add multiplier.
`default_nettype none
module fpmt_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire fpmt_pkg::cfg_t    cfg,
  input  wire logic         pop_valid,
  output logic              pop_ready,
  input  wire fpmt_pkg::totals_t pop_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              out_match
);

  localparam int SW    = fpmt_pkg::SUM_W;
  localparam int CMW   = fpmt_pkg::COS_W - 1;      // cosine magnitude bits
  localparam int C2W   = 2 * CMW;                  // limit squared
  localparam int LHS_W = 2 * SW;                   // P^2
  localparam int ACC_W = LHS_W + C2W;              // L*R*C^2 and P^2*2^30
  localparam int CNT_W = $clog2(SW + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PP   = 3'd1;
  localparam logic [2:0] ST_LR   = 3'd2;
  localparam logic [2:0] ST_RC   = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W-1:0] mcand_r, mcand_nxt;
  logic [SW-1:0]    mplier_r, mplier_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LHS_W-1:0] lhs_r, lhs_nxt;
  logic [SW-1:0]    lsq_r, lsq_nxt;
  logic [SW-1:0]    rsq_r, rsq_nxt;
  logic [C2W-1:0]   c2_r, c2_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_match_r, out_match_nxt;

  logic [ACC_W-1:0] acc_step;
  logic             last_step;
  logic             slot_free;
  logic             cos_nonpos;
  logic [CMW-1:0]   cmag;

  assign slot_free  = !out_valid_r || out_ready;
  assign pop_ready  = (state_r == ST_IDLE) && slot_free;
  assign out_valid  = out_valid_r;
  assign out_match  = out_match_r;
  assign cmag       = cfg.cosine_limit[CMW-1:0];
  assign cos_nonpos = cfg.cosine_limit[fpmt_pkg::COS_W-1] || (cmag == '0);
  assign acc_step   = acc_r + (mplier_r[0] ? mcand_r : '0);
  assign last_step  = cnt_r == CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    cnt_nxt       = cnt_r;
    lhs_nxt       = lhs_r;
    lsq_nxt       = lsq_r;
    rsq_nxt       = rsq_r;
    c2_nxt        = c2_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_match_nxt = out_match_r;

    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid && slot_free) begin
          if (cfg.metric_mode == fpmt_pkg::MODE_EUCLID) begin
            out_valid_nxt = 1'b1;
            out_match_nxt = {{(fpmt_pkg::DIST_W - fpmt_pkg::DIFF_W){1'b0}},
                             pop_data.diff_sq} < cfg.distance_limit;
          end else if (pop_data.left_sq == '0 || pop_data.right_sq == '0) begin
            out_valid_nxt = 1'b1;
            out_match_nxt = 1'b0;
          end else if (cos_nonpos) begin
            out_valid_nxt = 1'b1;
            out_match_nxt = 1'b1;
          end else begin
            // Start P*P; keep the norms and C^2 for the next passes.
            acc_nxt    = '0;
            mcand_nxt  = {{(ACC_W - SW){1'b0}}, pop_data.prod_abs};
            mplier_nxt = pop_data.prod_abs;
            cnt_nxt    = CNT_W'(SW);
            lsq_nxt    = pop_data.left_sq;
            rsq_nxt    = pop_data.right_sq;
            c2_nxt     = cmag * cmag;
            state_nxt  = ST_PP;
          end
        end
      end
      ST_PP, ST_LR, ST_RC: begin
        acc_nxt    = acc_step;
        mcand_nxt  = {mcand_r[ACC_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[SW-1:1]};
        cnt_nxt    = cnt_r - 1'b1;
        if (last_step) begin
          if (state_r == ST_PP) begin
            lhs_nxt    = acc_step[LHS_W-1:0];
            acc_nxt    = '0;
            mcand_nxt  = {{(ACC_W - SW){1'b0}}, lsq_r};
            mplier_nxt = rsq_r;
            cnt_nxt    = CNT_W'(SW);
            state_nxt  = ST_LR;
          end else if (state_r == ST_LR) begin
            acc_nxt    = '0;
            mcand_nxt  = acc_step;
            mplier_nxt = {{(SW - C2W){1'b0}}, c2_r};
            cnt_nxt    = CNT_W'(C2W);
            state_nxt  = ST_RC;
          end else begin
            state_nxt  = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_match_nxt = {lhs_r, {C2W{1'b0}}} >= acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    cnt_r       <= cnt_nxt;
    lhs_r       <= lhs_nxt;
    lsq_r       <= lsq_nxt;
    rsq_r       <= rsq_nxt;
    c2_r        <= c2_nxt;
    out_match_r <= out_match_nxt;
  end

endmodule
`default_nettype wire

/* rtl/feature_pair_match_threshold_unit.sv */
// Top level of the feature pair match unit: configuration, front end, queue, sequencer.
`default_nettype none
// Streams two feature vectors in as one Q4.12 element pair per request (left in
// tdata[15:0], right in tdata[31:16], tlast on the last pair) and returns one
// match request per vector pair in out_tdata[0]. The front end takes one pair
// every cycle unless stalled: a product stage registers |a-b|^2, |a|*|b|, a^2
// and b^2, and an accumulate stage adds them into four saturating sums. The
// sums of each finished vector pair drop into a two-entry queue, so the front
// end keeps accepting the next vector while the sequencer judges the last one.
// In Euclidean mode, and in cosine mode when a norm is zero or the limit is
// not positive, the result is valid from the edge at which the sums leave the
// queue. Otherwise the sequencer picks the sums up, runs its one-bit-per-cycle
// shift-add multiplier three times (P*P, then L*R, then that product times the
// limit squared) and then compares the results. The front end stalls only when
// both queue entries are full, so cosine vectors stream at one pair per cycle
// while the sequencer keeps up. Write configuration only while no request is
// in flight; registers reset to Euclidean mode, a distance limit of 1.0 and a
// cosine limit of 0.5. There is no clearing pass.
module feature_pair_match_threshold_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [fpmt_pkg::TDATA_IN_W-1:0]     in_tdata,   // left_value, right_value
  input  wire logic                                in_tlast,   // final_element
  // Result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [fpmt_pkg::TDATA_OUT_W-1:0]         out_tdata,  // pair_match, 7 zero bits
  // Configuration write port
  input  wire logic                                cfg_wr_en,
  input  wire logic [fpmt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fpmt_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int EW = fpmt_pkg::ELEM_W;

  fpmt_pkg::cfg_t    cfg_r, cfg_nxt;
  fpmt_pkg::totals_t push_data;
  fpmt_pkg::totals_t pop_data;
  logic              push_valid;
  logic              push_ready;
  logic              pop_valid;
  logic              pop_ready;
  logic              pair_match;

  // Decode register writes; an index beyond the list writes nothing.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        fpmt_pkg::REG_METRIC_MODE:    cfg_nxt.metric_mode    = cfg_wdata[0];
        fpmt_pkg::REG_DISTANCE_LIMIT: cfg_nxt.distance_limit = cfg_wdata;
        fpmt_pkg::REG_COSINE_LIMIT:   cfg_nxt.cosine_limit   =
                                        cfg_wdata[fpmt_pkg::COS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.metric_mode    <= fpmt_pkg::MODE_EUCLID;
      cfg_r.distance_limit <= fpmt_pkg::DIST_W'(48'd16777216);
      cfg_r.cosine_limit   <= fpmt_pkg::COS_W'(16'd16384);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fpmt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .left_value    (in_tdata[EW-1:0]),
    .right_value   (in_tdata[2*EW-1:EW]),
    .final_element (in_tlast),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  fpmt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  fpmt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_match (pair_match)
  );

  // Pad the single result bit to a whole byte.
  assign out_tdata = {{(fpmt_pkg::TDATA_OUT_W - 1){1'b0}}, pair_match};

endmodule
`default_nettype wire

/* rtl/fpmt_checker.sv */
// Port-level checker of the feature pair match unit and its bind.
`default_nettype none
`include "feature_pair_match_threshold_unit_macros.svh"
module fpmt_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [fpmt_pkg::TDATA_OUT_W-1:0]  out_tdata
);

  `FPMT_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result request dropped while stalled")
  `FPMT_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata), "result changed while stalled")
  `FPMT_ASSERT(a_out_pad, out_tvalid |-> out_tdata[fpmt_pkg::TDATA_OUT_W-1:1] == '0, "result padding not zero")
  `FPMT_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind feature_pair_match_threshold_unit fpmt_checker u_fpmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
